FILE: rtl/core/bmcs_pkg.sv
// ----------------------------------------------------------------------------
// bmcs_pkg: shared types and constants for best master clock selection
// Holds the priority vector type, request kinds, roles and csr indexes.
// ----------------------------------------------------------------------------
package bmcs_pkg;

   localparam logic [1:0] KIND_ANNOUNCE   = 2'd0;
   localparam logic [1:0] KIND_INVALIDATE = 2'd1;
   localparam logic [1:0] KIND_RUN        = 2'd2;

   localparam logic [1:0] ROLE_MASTER  = 2'd0;
   localparam logic [1:0] ROLE_SLAVE   = 2'd1;
   localparam logic [1:0] ROLE_PASSIVE = 2'd2;

   localparam logic [2:0] CSR_PRIORITY1 = 3'd0;
   localparam logic [2:0] CSR_PRIORITY2 = 3'd1;
   localparam logic [2:0] CSR_CLASS     = 3'd2;
   localparam logic [2:0] CSR_ACCURACY  = 3'd3;
   localparam logic [2:0] CSR_VARIANCE  = 3'd4;
   localparam logic [2:0] CSR_IDENTITY  = 3'd5;

   localparam logic [7:0]  BAD_CLASS     = 8'd255;
   localparam logic [7:0]  BAD_PRIORITY  = 8'd255;
   localparam logic [7:0]  RST_PRIORITY  = 8'd248;
   localparam logic [7:0]  RST_CLASS     = 8'd248;
   localparam logic [7:0]  RST_ACCURACY  = 8'd41;
   localparam logic [15:0] RST_VARIANCE  = 16'h4000;

   localparam int VEC_W = 8 + 8 + 8 + 16 + 8 + 64 + 16 + 64;

   typedef struct packed {
      logic [7:0]  p1;
      logic [7:0]  cls;
      logic [7:0]  acc;
      logic [15:0] var_v;
      logic [7:0]  p2;
      logic [63:0] gm;
      logic [15:0] steps;
      logic [63:0] sender;
   } pvec_type;

   // queue entry between front and back
   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] port;
      logic       valid_mark;
      pvec_type   vec;
   } cmd_type;

   // packed field order equals compare order, so one unsigned compare works
   function automatic logic [1:0] vec_cmp(input pvec_type a, input pvec_type b);
      logic [1:0] r;
      if (a < b) r = 2'd1;       // a better
      else if (a > b) r = 2'd2;  // b better
      else r = 2'd0;
      return r;
   endfunction

endpackage

FILE: rtl/core/bmcs_ram.sv
// ----------------------------------------------------------------------------
// bmcs_ram: generic single write, single read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module bmcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

FILE: rtl/core/bmcs_front.sv
// ----------------------------------------------------------------------------
// bmcs_front: request intake and classification
// Qualifies announces, drops bad ports and unused kinds, feeds a short queue.
// ----------------------------------------------------------------------------
module bmcs_front #(
   parameter int NUM_PORTS   = 8,
   parameter int STEPS_LIMIT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [2:0]        req_port,
   input  bmcs_pkg::pvec_type req_vec,
   output logic              q_valid,
   input  logic              q_ready,
   output bmcs_pkg::cmd_type q_cmd
);
   localparam int SLOTS = (NUM_PORTS < 8) ? NUM_PORTS : 8;

   // two entry queue
   bmcs_pkg::cmd_type ent_ff [2];
   logic [1:0] cnt_ff;
   logic       rp_ff, wp_ff;
   logic       push, pop, keep;
   bmcs_pkg::cmd_type cmd;

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = ent_ff[rp_ff];
   assign pop       = q_valid && q_ready;

   always_comb begin
      cmd.kind = req_kind;
      cmd.port = req_port;
      cmd.vec  = req_vec;
      cmd.valid_mark = (req_vec.steps < 16'(STEPS_LIMIT))
                       && (req_vec.cls != bmcs_pkg::BAD_CLASS)
                       && !(req_vec.p1 == bmcs_pkg::BAD_PRIORITY
                            && req_vec.p2 == bmcs_pkg::BAD_PRIORITY);
      keep = (req_kind == bmcs_pkg::KIND_RUN)
             || ((req_kind == bmcs_pkg::KIND_ANNOUNCE
                  || req_kind == bmcs_pkg::KIND_INVALIDATE)
                 && ({1'b0, req_port} < 4'(SLOTS)));
   end

   assign push = req_valid && req_ready && keep;

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= cmd;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

FILE: rtl/core/bmcs_back.sv
// ----------------------------------------------------------------------------
// bmcs_back: port table and selection sequencer
// Stores vectors in RAM, walks ports to qualify, then again to emit roles.
// ----------------------------------------------------------------------------
module bmcs_back #(
   parameter int NUM_PORTS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  bmcs_pkg::cmd_type  q_cmd,
   input  bmcs_pkg::pvec_type loc_vec,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_out_port,
   output logic [1:0]         rsp_role,
   output logic               rsp_local_is_grandmaster,
   output logic               rsp_role_changed,
   output logic [2:0]         rsp_best_port,
   output logic               rsp_best_found,
   output logic               rsp_last
);
   localparam int SLOTS = (NUM_PORTS < 8) ? NUM_PORTS : 8;
   localparam logic [2:0] LAST_SLOT = 3'(SLOTS - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_QRD  = 3'd1; // address issued, wait data
   localparam logic [2:0] ST_QCMP = 3'd2;
   localparam logic [2:0] ST_ERD  = 3'd3;
   localparam logic [2:0] ST_EOUT = 3'd4;
   localparam logic [2:0] ST_EWT  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [7:0]  known_ff, valid_ff;
   logic        gmf_ff;
   logic        gm_ff, gm_in, found_ff, found_in, chg_ff, chg_in;
   logic [2:0]  best_ff, best_in;
   bmcs_pkg::pvec_type best_vec_ff, best_vec_in;
   logic [2:0]  lastk_ff, lastk_in;

   logic               wr_en;
   logic [2:0]         rd_addr;
   bmcs_pkg::pvec_type rd_vec;

   bmcs_ram #(.WIDTH(bmcs_pkg::VEC_W), .DEPTH(8)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(q_cmd.port),
      .wr_data(q_cmd.vec),
      .rd_addr(rd_addr),
      .rd_data(rd_vec)
   );

   // output register
   logic       ov_ff;
   logic [2:0] o_port_ff, o_best_ff;
   logic [1:0] o_role_ff;
   logic       o_gm_ff, o_chg_ff, o_found_ff, o_last_ff;
   logic       emit;
   logic [1:0] role;
   logic [1:0] c_loc, c_best;

   assign rsp_valid = ov_ff;
   assign rsp_out_port = o_port_ff;
   assign rsp_role = o_role_ff;
   assign rsp_local_is_grandmaster = o_gm_ff;
   assign rsp_role_changed = o_chg_ff;
   assign rsp_best_port = o_best_ff;
   assign rsp_best_found = o_found_ff;
   assign rsp_last = o_last_ff;

   assign q_ready = (state_ff == ST_IDLE);
   assign wr_en   = q_ready && q_valid && (q_cmd.kind == bmcs_pkg::KIND_ANNOUNCE);
   assign c_loc   = bmcs_pkg::vec_cmp(loc_vec, rd_vec);
   assign c_best  = bmcs_pkg::vec_cmp(rd_vec, best_vec_ff);

   always_comb begin
      unique case (c_loc)
         2'd1:    role = bmcs_pkg::ROLE_MASTER;
         2'd2:    role = bmcs_pkg::ROLE_SLAVE;
         default: role = bmcs_pkg::ROLE_PASSIVE;
      endcase
      if (gm_ff || !valid_ff[idx_ff]) role = bmcs_pkg::ROLE_MASTER;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      gm_in = gm_ff;
      found_in = found_ff;
      chg_in = chg_ff;
      best_in = best_ff;
      best_vec_in = best_vec_ff;
      lastk_in = lastk_ff;
      rd_addr = idx_ff;
      emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = 3'd0;
            if (q_valid && q_cmd.kind == bmcs_pkg::KIND_RUN) begin
               idx_in = 3'd0;
               gm_in = 1'b1;
               found_in = 1'b0;
               best_in = 3'd0;
               lastk_in = 3'd0;
               state_in = ST_QRD;
            end
         end
         ST_QRD: state_in = ST_QCMP;
         ST_QCMP: begin
            if (valid_ff[idx_ff]) begin
               if (c_loc != 2'd1) gm_in = 1'b0;
               if (!found_ff || c_best == 2'd1) begin
                  best_in = idx_ff;
                  best_vec_in = rd_vec;
                  found_in = 1'b1;
               end
            end
            if (known_ff[idx_ff]) lastk_in = idx_ff;
            if (idx_ff == LAST_SLOT) begin
               if (gm_in) begin
                  found_in = 1'b0;
                  best_in = 3'd0;
               end
               chg_in = (gm_in != gmf_ff);
               idx_in = 3'd0;
               rd_addr = 3'd0;
               state_in = ST_ERD;
            end else begin
               idx_in = idx_ff + 3'd1;
               rd_addr = idx_in;
               state_in = ST_QCMP;
            end
         end
         ST_ERD: state_in = ST_EOUT;
         ST_EOUT: begin
            if (!known_ff[idx_ff] || !ov_ff || rsp_ready) begin
               emit = known_ff[idx_ff];
               if (idx_ff == LAST_SLOT) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  rd_addr = idx_in;
               end
            end else begin
               state_in = ST_EWT;
            end
         end
         ST_EWT: begin
            // hold read data steady while the output stalls
            if (rsp_ready) state_in = ST_EOUT;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      best_vec_ff <= best_vec_in;
      best_ff <= best_in;
      lastk_ff <= lastk_in;
      chg_ff <= chg_in;
      found_ff <= found_in;
      gm_ff <= gm_in;
      idx_ff <= idx_in;
      if (emit) begin
         o_port_ff  <= idx_ff;
         o_role_ff  <= role;
         o_gm_ff    <= gm_ff;
         o_chg_ff   <= chg_ff;
         o_best_ff  <= best_ff;
         o_found_ff <= found_ff;
         o_last_ff  <= (idx_ff == lastk_ff);
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         known_ff <= '0;
         valid_ff <= '0;
         gmf_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) ov_ff <= 1'b1;
         else if (rsp_ready) ov_ff <= 1'b0;
         if (state_ff == ST_QCMP && idx_ff == LAST_SLOT) gmf_ff <= gm_in;
         if (q_ready && q_valid) begin
            if (q_cmd.kind == bmcs_pkg::KIND_ANNOUNCE) begin
               known_ff[q_cmd.port] <= 1'b1;
               valid_ff[q_cmd.port] <= q_cmd.valid_mark;
            end else if (q_cmd.kind == bmcs_pkg::KIND_INVALIDATE) begin
               valid_ff[q_cmd.port] <= 1'b0;
            end
         end
      end
   end
endmodule

FILE: rtl/core/best_master_clock_selection_unit.sv
// ----------------------------------------------------------------------------
// best_master_clock_selection_unit: best master clock selection over ports
// Stores announced priority vectors per port and, on a run request, emits
// one role decision per known port in ascending port order.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  req_      in    req_valid/req_ready   kind, port, announced vector
//  rsp_      out   rsp_valid/rsp_ready   one role decision per known port
//  csr_      in    csr_valid/csr_ready   csr_index, csr_data
//
// Announce and invalidate requests retire while the sequencer is idle. A run holds
// the sequencer through intake, a RAM read-latency state, one compare per port, a
// second read-latency state and one emit per port; the single read port of the
// vector RAM sets this sequence.
// An output stall parks the sequencer in a wait state until rsp_ready; a
// two-entry queue parts intake from the sequencer. Reset is synchronous and
// clears known/valid marks and the grandmaster flag.
module best_master_clock_selection_unit #(
   parameter int NUM_PORTS   = 8,
   parameter int STEPS_LIMIT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [2:0]  req_port,
   input  logic [7:0]  req_gm_priority1,
   input  logic [7:0]  req_gm_clock_class,
   input  logic [7:0]  req_gm_clock_accuracy,
   input  logic [15:0] req_gm_log_variance,
   input  logic [7:0]  req_gm_priority2,
   input  logic [63:0] req_gm_identity,
   input  logic [63:0] req_sender_identity,
   input  logic [15:0] req_steps_removed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_port,
   output logic [1:0]  rsp_role,
   output logic        rsp_local_is_grandmaster,
   output logic        rsp_role_changed,
   output logic [2:0]  rsp_best_port,
   output logic        rsp_best_found,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   logic [7:0]  p1_ff, p2_ff, cls_ff, acc_ff;
   logic [15:0] var_ff;
   logic [63:0] id_ff;

   bmcs_pkg::pvec_type req_vec, loc_vec;
   bmcs_pkg::cmd_type  q_cmd;
   logic               q_valid, q_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff  <= bmcs_pkg::RST_PRIORITY;
         p2_ff  <= bmcs_pkg::RST_PRIORITY;
         cls_ff <= bmcs_pkg::RST_CLASS;
         acc_ff <= bmcs_pkg::RST_ACCURACY;
         var_ff <= bmcs_pkg::RST_VARIANCE;
         id_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bmcs_pkg::CSR_PRIORITY1: p1_ff  <= csr_data[7:0];
            bmcs_pkg::CSR_PRIORITY2: p2_ff  <= csr_data[7:0];
            bmcs_pkg::CSR_CLASS:     cls_ff <= csr_data[7:0];
            bmcs_pkg::CSR_ACCURACY:  acc_ff <= csr_data[7:0];
            bmcs_pkg::CSR_VARIANCE:  var_ff <= csr_data[15:0];
            bmcs_pkg::CSR_IDENTITY:  id_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_vec.p1     = req_gm_priority1;
      req_vec.cls    = req_gm_clock_class;
      req_vec.acc    = req_gm_clock_accuracy;
      req_vec.var_v  = req_gm_log_variance;
      req_vec.p2     = req_gm_priority2;
      req_vec.gm     = req_gm_identity;
      req_vec.steps  = req_steps_removed;
      req_vec.sender = req_sender_identity;
      // local vector: sender is ourselves, zero steps removed
      loc_vec.p1     = p1_ff;
      loc_vec.cls    = cls_ff;
      loc_vec.acc    = acc_ff;
      loc_vec.var_v  = var_ff;
      loc_vec.p2     = p2_ff;
      loc_vec.gm     = id_ff;
      loc_vec.steps  = '0;
      loc_vec.sender = id_ff;
   end

   bmcs_front #(.NUM_PORTS(NUM_PORTS), .STEPS_LIMIT(STEPS_LIMIT)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind (req_kind),
      .req_port (req_port),
      .req_vec  (req_vec),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   bmcs_back #(.NUM_PORTS(NUM_PORTS)) u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_valid                 (q_valid),
      .q_ready                 (q_ready),
      .q_cmd                   (q_cmd),
      .loc_vec                 (loc_vec),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_out_port            (rsp_out_port),
      .rsp_role                (rsp_role),
      .rsp_local_is_grandmaster(rsp_local_is_grandmaster),
      .rsp_role_changed        (rsp_role_changed),
      .rsp_best_port           (rsp_best_port),
      .rsp_best_found          (rsp_best_found),
      .rsp_last                (rsp_last)
   );
endmodule
